FILE: rtl/pmpc_pkg.sv
package pmpc_pkg;

    // Field widths
    localparam int COUNT_W    = 16;
    localparam int US_W       = 24;
    localparam int SP_W       = 24;
    localparam int GAIN_W     = 16;
    localparam int ERR_W      = 32;
    localparam int INTEG_W    = 48;
    localparam int INTEG_LO_W = 24;
    localparam int DRIVE_W    = 16;
    localparam int SPEED_W    = 16;

    // Stream and configuration port widths
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Shared multiplier: signed 33 x signed 25
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 25;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = 64;

    // Shared divider: 58-bit magnitude over a 24-bit divisor, two bits a cycle
    localparam int DIVD_W         = 58;
    localparam int DIVS_W         = 24;
    localparam int DIV_RADIX_BITS = 2;
    localparam int DIV_STEPS      = DIVD_W / DIV_RADIX_BITS;
    localparam int DIV_CNT_W      = $clog2(DIV_STEPS);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SET_POINT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DEG_PER_CNT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DZ_OFFSET  = 3'd6;

    // Register reset values
    localparam logic signed [SP_W-1:0] SET_POINT_RST = 24'sd23040;
    localparam logic [GAIN_W-1:0] GAIN_P_RST      = 16'd3277;
    localparam logic [GAIN_W-1:0] GAIN_I_RST      = 16'd41;
    localparam logic [GAIN_W-1:0] GAIN_D_RST      = 16'd3686;
    localparam logic [GAIN_W-1:0] DEADBAND_RST    = 16'd1280;
    localparam logic [GAIN_W-1:0] DEG_PER_CNT_RST = 16'd1152;
    localparam logic [GAIN_W-1:0] DZ_OFFSET_RST   = 16'd54613;

    // Arithmetic constants
    localparam logic signed [MUL_B_W-1:0] US_PER_SEC  = 25'sd1000000;
    localparam logic signed [MUL_B_W-1:0] DRIVE_FULL  = 25'sd25600;
    localparam logic [DIVS_W-1:0]         INTEG_DIVISOR = 24'd15625;
    localparam logic [DIVS_W-1:0]         SPEED_DIVISOR = 24'd51200;
    localparam logic signed [ACC_W-1:0]   SUM_LIMIT   = 64'sd104857600;
    localparam logic [GAIN_W:0]           OFFSET_ONE  = 17'd65536;

    typedef struct packed {
        logic signed [SP_W-1:0] set_point;
        logic [GAIN_W-1:0]      gain_p;
        logic [GAIN_W-1:0]      gain_i;
        logic [GAIN_W-1:0]      gain_d;
        logic [GAIN_W-1:0]      deadband;
        logic [GAIN_W-1:0]      deg_per_count;
        logic [GAIN_W-1:0]      dz_offset;
    } cfg_t;

    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_ANGLE,
        MUL_ERR_US,
        MUL_DIFF,
        MUL_KP,
        MUL_KI_HI,
        MUL_KI_LO,
        MUL_KD,
        MUL_DRV,
        MUL_OFF
    } mul_sel_t;

    typedef enum logic [1:0] {
        DIV_INTEG,
        DIV_DERIV,
        DIV_SPEED
    } div_sel_t;

    typedef enum logic [3:0] {
        DP_NONE,
        DP_LOAD,
        DP_ERR,
        DP_CHECK,
        DP_INTEG,
        DP_DERIV,
        DP_DZERO,
        DP_PREV,
        DP_ACC_LOAD,
        DP_TMP_HI,
        DP_TMP_ADD,
        DP_SUM1,
        DP_SUM2,
        DP_CLAMP,
        DP_SPD_ADD,
        DP_SPEED
    } dp_op_t;

    typedef struct packed {
        dp_op_t   op;
        mul_sel_t mul;
        logic     div_start;
        div_sel_t div_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic in_band;
        logic us_zero;
        logic drive_zero;
        logic div_done;
    } dp_stat_t;

    typedef struct packed {
        logic                      updated;
        logic signed [ERR_W-1:0]   angle_error;
        logic signed [DRIVE_W-1:0] drive;
        logic signed [SPEED_W-1:0] speed;
    } result_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ANGLE,
        ST_ERR,
        ST_CHECK,
        ST_IDIV,
        ST_IDIV_WAIT,
        ST_DDIV,
        ST_DDIV_WAIT,
        ST_KP,
        ST_KI_HI,
        ST_KI_LO,
        ST_KD,
        ST_SUM1,
        ST_SUM2,
        ST_CLAMP,
        ST_SPD1,
        ST_SPD2,
        ST_SPD3,
        ST_SDIV,
        ST_SDIV_WAIT,
        ST_DONE
    } ctrl_state_t;

endpackage

FILE: rtl/pmpc_div.sv
module pmpc_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [pmpc_pkg::ACC_W-1:0]   dividend,
    input  logic        [pmpc_pkg::DIVS_W-1:0]  divisor,
    output logic                                done,
    output logic signed [pmpc_pkg::ACC_W-1:0]   quotient
);
    import pmpc_pkg::*;

    logic                   run_reg, run_next;
    logic                   fix_reg, fix_next;
    logic                   done_reg, done_next;
    logic [DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                   neg_reg, neg_next;
    logic [DIVD_W-1:0]      quo_reg, quo_next;
    logic [DIVS_W-1:0]      rem_reg, rem_next;
    logic [DIVS_W-1:0]      dsr_reg, dsr_next;
    logic signed [ACC_W-1:0] res_reg, res_next;

    logic [ACC_W-1:0]       mag;
    logic [DIVD_W-1:0]      q_step;
    logic [DIVS_W-1:0]      r_step;
    logic [DIVS_W:0]        r_ext;
    logic signed [ACC_W-1:0] quo_wide;

    assign mag      = dividend[ACC_W-1] ? $unsigned(-dividend) : $unsigned(dividend);
    assign quo_wide = $signed({{(ACC_W-DIVD_W){1'b0}}, quo_reg});

    // Restoring division, DIV_RADIX_BITS quotient bits per cycle
    always_comb
    begin
        q_step = quo_reg;
        r_step = rem_reg;
        r_ext  = '0;
        for (int i = 0; i < DIV_RADIX_BITS; i++)
        begin
            r_ext  = {r_step, q_step[DIVD_W-1]};
            q_step = {q_step[DIVD_W-2:0], 1'b0};
            if (r_ext >= {1'b0, dsr_reg})
            begin
                r_ext     = r_ext - {1'b0, dsr_reg};
                q_step[0] = 1'b1;
            end
            r_step = r_ext[DIVS_W-1:0];
        end
    end

    always_comb
    begin
        run_next  = run_reg;
        fix_next  = 1'b0;
        done_next = fix_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        res_next  = res_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            neg_next = dividend[ACC_W-1];
            quo_next = mag[DIVD_W-1:0];
            rem_next = '0;
            dsr_next = divisor;
        end
        else if (run_reg)
        begin
            quo_next = q_step;
            rem_next = r_step;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
            begin
                run_next = 1'b0;
                fix_next = 1'b1;
            end
        end
        // restore the sign: truncation toward zero
        if (fix_reg)
        begin
            res_next = neg_reg ? -quo_wide : quo_wide;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            fix_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            fix_reg  <= fix_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        res_reg <= res_next;
    end

    assign done     = done_reg;
    assign quotient = res_reg;

endmodule

FILE: rtl/pmpc_dp.sv
module pmpc_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  pmpc_pkg::dp_cmd_t                    cmd,
    input  pmpc_pkg::cfg_t                       cfg,
    input  logic signed [pmpc_pkg::COUNT_W-1:0]  in_count,
    input  logic        [pmpc_pkg::US_W-1:0]     in_us,
    output pmpc_pkg::dp_stat_t                   stat,
    output pmpc_pkg::result_t                    res
);
    import pmpc_pkg::*;

    logic signed [COUNT_W-1:0] count_reg, count_next;
    logic [US_W-1:0]           us_reg, us_next;
    logic signed [ERR_W-1:0]   err_reg, err_next;
    logic                      upd_reg, upd_next;
    logic signed [PROD_W-1:0]  p_reg, p_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic signed [ACC_W-1:0]   tmp_reg, tmp_next;
    logic signed [INTEG_W-1:0] integ_reg, integ_next;
    logic signed [ERR_W-1:0]   prev_reg, prev_next;
    logic signed [ERR_W-1:0]   deriv_reg, deriv_next;
    logic signed [DRIVE_W-1:0] drive_reg, drive_next;
    logic signed [SPEED_W-1:0] speed_reg, speed_next;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod;
    logic signed [ACC_W-1:0]   p_ext;
    logic signed [MUL_A_W-1:0] diff;
    logic signed [ERR_W+1:0]   err_wide;
    logic [ERR_W:0]            err_ext;
    logic [ERR_W:0]            err_mag;
    logic signed [INTEG_W+1:0] integ_sum;
    logic signed [ACC_W-1:0]   tmp_bias;
    logic signed [ACC_W-1:0]   sum_clamp;
    logic signed [27:0]        drive_bias;
    logic signed [27:0]        drive_shift;
    logic signed [ACC_W-1:0]   div_dividend;
    logic [DIVS_W-1:0]         div_divisor;
    logic                      div_done;
    logic signed [ACC_W-1:0]   div_quo;

    assign p_ext = {{(ACC_W-PROD_W){p_reg[PROD_W-1]}}, p_reg};
    assign diff  = {err_reg[ERR_W-1], err_reg} - {prev_reg[ERR_W-1], prev_reg};

    // Operand select for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul)
            MUL_ANGLE:
            begin
                mul_a = {{(MUL_A_W-COUNT_W){count_reg[COUNT_W-1]}}, count_reg};
                mul_b = {{(MUL_B_W-GAIN_W){1'b0}}, cfg.deg_per_count};
            end
            MUL_ERR_US:
            begin
                mul_a = {err_reg[ERR_W-1], err_reg};
                mul_b = {{(MUL_B_W-US_W){1'b0}}, us_reg};
            end
            MUL_DIFF:
            begin
                mul_a = diff;
                mul_b = US_PER_SEC;
            end
            MUL_KP:
            begin
                mul_a = {err_reg[ERR_W-1], err_reg};
                mul_b = {{(MUL_B_W-GAIN_W){1'b0}}, cfg.gain_p};
            end
            MUL_KI_HI:
            begin
                mul_a = {{(MUL_A_W-INTEG_W+INTEG_LO_W){integ_reg[INTEG_W-1]}},
                         integ_reg[INTEG_W-1:INTEG_LO_W]};
                mul_b = {{(MUL_B_W-GAIN_W){1'b0}}, cfg.gain_i};
            end
            MUL_KI_LO:
            begin
                mul_a = {{(MUL_A_W-INTEG_LO_W){1'b0}}, integ_reg[INTEG_LO_W-1:0]};
                mul_b = {{(MUL_B_W-GAIN_W){1'b0}}, cfg.gain_i};
            end
            MUL_KD:
            begin
                mul_a = {deriv_reg[ERR_W-1], deriv_reg};
                mul_b = {{(MUL_B_W-GAIN_W){1'b0}}, cfg.gain_d};
            end
            MUL_DRV:
            begin
                mul_a = {{(MUL_A_W-DRIVE_W){drive_reg[DRIVE_W-1]}}, drive_reg};
                mul_b = {{(MUL_B_W-GAIN_W-1){1'b0}}, OFFSET_ONE - {1'b0, cfg.dz_offset}};
            end
            MUL_OFF:
            begin
                mul_a = {{(MUL_A_W-GAIN_W){1'b0}}, cfg.dz_offset};
                mul_b = DRIVE_FULL;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // Error, magnitude and saturation helpers
    assign err_wide  = {{(ERR_W+2-SP_W){cfg.set_point[SP_W-1]}}, cfg.set_point}
                     - p_reg[ERR_W+1:0];
    assign err_ext   = {err_reg[ERR_W-1], err_reg};
    assign err_mag   = err_ext[ERR_W] ? (~err_ext + 1'b1) : err_ext;
    assign integ_sum = {{2{integ_reg[INTEG_W-1]}}, integ_reg} + div_quo[INTEG_W+1:0];
    assign tmp_bias  = tmp_reg + (tmp_reg[ACC_W-1] ? 64'sd255 : 64'sd0);

    always_comb
    begin
        if (acc_reg > SUM_LIMIT)
        begin
            sum_clamp = SUM_LIMIT;
        end
        else if (acc_reg < -SUM_LIMIT)
        begin
            sum_clamp = -SUM_LIMIT;
        end
        else
        begin
            sum_clamp = acc_reg;
        end
    end

    assign drive_bias  = sum_clamp[27:0] + (sum_clamp[ACC_W-1] ? 28'sd4095 : 28'sd0);
    assign drive_shift = drive_bias >>> 12;

    // Divider operand select
    always_comb
    begin
        case (cmd.div_sel)
            DIV_INTEG:
            begin
                div_dividend = p_ext <<< 2;
                div_divisor  = INTEG_DIVISOR;
            end
            DIV_DERIV:
            begin
                div_dividend = p_ext;
                div_divisor  = us_reg;
            end
            DIV_SPEED:
            begin
                div_dividend = acc_reg;
                div_divisor  = SPEED_DIVISOR;
            end
            default:
            begin
                div_dividend = '0;
                div_divisor  = SPEED_DIVISOR;
            end
        endcase
    end

    pmpc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb
    begin
        count_next = count_reg;
        us_next    = us_reg;
        err_next   = err_reg;
        upd_next   = upd_reg;
        p_next     = (cmd.mul != MUL_NONE) ? prod : p_reg;
        acc_next   = acc_reg;
        tmp_next   = tmp_reg;
        integ_next = integ_reg;
        prev_next  = prev_reg;
        deriv_next = deriv_reg;
        drive_next = drive_reg;
        speed_next = speed_reg;
        case (cmd.op)
            DP_LOAD:
            begin
                count_next = in_count;
                us_next    = in_us;
            end
            DP_ERR:
            begin
                if (err_wide[ERR_W+1:ERR_W-1] == 3'b000 ||
                    err_wide[ERR_W+1:ERR_W-1] == 3'b111)
                begin
                    err_next = err_wide[ERR_W-1:0];
                end
                else
                begin
                    err_next = {err_wide[ERR_W+1], {(ERR_W-1){~err_wide[ERR_W+1]}}};
                end
            end
            DP_CHECK:
            begin
                upd_next   = ~stat.in_band;
                drive_next = '0;
                speed_next = '0;
            end
            DP_INTEG:
            begin
                if (integ_sum[INTEG_W+1:INTEG_W-1] == 3'b000 ||
                    integ_sum[INTEG_W+1:INTEG_W-1] == 3'b111)
                begin
                    integ_next = integ_sum[INTEG_W-1:0];
                end
                else
                begin
                    integ_next = {integ_sum[INTEG_W+1],
                                  {(INTEG_W-1){~integ_sum[INTEG_W+1]}}};
                end
            end
            DP_DERIV:
            begin
                if ((&div_quo[ACC_W-1:ERR_W-1]) || !(|div_quo[ACC_W-1:ERR_W-1]))
                begin
                    deriv_next = div_quo[ERR_W-1:0];
                end
                else
                begin
                    deriv_next = {div_quo[ACC_W-1], {(ERR_W-1){~div_quo[ACC_W-1]}}};
                end
            end
            DP_DZERO:
            begin
                deriv_next = '0;
            end
            DP_PREV:
            begin
                prev_next = err_reg;
            end
            DP_ACC_LOAD:
            begin
                acc_next = p_ext;
            end
            DP_TMP_HI:
            begin
                tmp_next = p_ext <<< INTEG_LO_W;
            end
            DP_TMP_ADD:
            begin
                tmp_next = tmp_reg + p_ext;
            end
            DP_SUM1:
            begin
                acc_next = acc_reg + p_ext;
                tmp_next = tmp_bias >>> 8;
            end
            DP_SUM2:
            begin
                acc_next = acc_reg + tmp_reg;
            end
            DP_CLAMP:
            begin
                drive_next = drive_shift[DRIVE_W-1:0];
            end
            DP_SPD_ADD:
            begin
                acc_next = drive_reg[DRIVE_W-1] ? (acc_reg - p_ext) : (acc_reg + p_ext);
            end
            DP_SPEED:
            begin
                if ((&div_quo[ACC_W-1:SPEED_W-1]) || !(|div_quo[ACC_W-1:SPEED_W-1]))
                begin
                    speed_next = div_quo[SPEED_W-1:0];
                end
                else
                begin
                    speed_next = {div_quo[ACC_W-1], {(SPEED_W-1){~div_quo[ACC_W-1]}}};
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg <= '0;
            prev_reg  <= '0;
        end
        else
        begin
            integ_reg <= integ_next;
            prev_reg  <= prev_next;
        end
    end

    always_ff @(posedge clk)
    begin
        count_reg <= count_next;
        us_reg    <= us_next;
        err_reg   <= err_next;
        upd_reg   <= upd_next;
        p_reg     <= p_next;
        acc_reg   <= acc_next;
        tmp_reg   <= tmp_next;
        deriv_reg <= deriv_next;
        drive_reg <= drive_next;
        speed_reg <= speed_next;
    end

    assign stat.in_band    = (err_mag <= {{(ERR_W+1-GAIN_W){1'b0}}, cfg.deadband});
    assign stat.us_zero    = (us_reg == '0);
    assign stat.drive_zero = (drive_reg == '0);
    assign stat.div_done   = div_done;

    assign res.updated     = upd_reg;
    assign res.angle_error = err_reg;
    assign res.drive       = drive_reg;
    assign res.speed       = speed_reg;

endmodule

FILE: rtl/pmpc_ctrl.sv
module pmpc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                out_free,
    input  pmpc_pkg::dp_stat_t  stat,
    output logic                in_ready,
    output logic                res_load,
    output pmpc_pkg::dp_cmd_t   cmd
);
    import pmpc_pkg::*;

    ctrl_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:      if (in_valid) state_next = ST_ANGLE;
            ST_ANGLE:     state_next = ST_ERR;
            ST_ERR:       state_next = ST_CHECK;
            ST_CHECK:     state_next = stat.in_band ? ST_DONE : ST_IDIV;
            ST_IDIV:      state_next = ST_IDIV_WAIT;
            ST_IDIV_WAIT: if (stat.div_done) state_next = ST_DDIV;
            ST_DDIV:      state_next = stat.us_zero ? ST_KP : ST_DDIV_WAIT;
            ST_DDIV_WAIT: if (stat.div_done) state_next = ST_KP;
            ST_KP:        state_next = ST_KI_HI;
            ST_KI_HI:     state_next = ST_KI_LO;
            ST_KI_LO:     state_next = ST_KD;
            ST_KD:        state_next = ST_SUM1;
            ST_SUM1:      state_next = ST_SUM2;
            ST_SUM2:      state_next = ST_CLAMP;
            ST_CLAMP:     state_next = ST_SPD1;
            ST_SPD1:      state_next = stat.drive_zero ? ST_DONE : ST_SPD2;
            ST_SPD2:      state_next = ST_SPD3;
            ST_SPD3:      state_next = ST_SDIV;
            ST_SDIV:      state_next = ST_SDIV_WAIT;
            ST_SDIV_WAIT: if (stat.div_done) state_next = ST_DONE;
            ST_DONE:      if (out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready      = 1'b0;
        res_load      = 1'b0;
        cmd.op        = DP_NONE;
        cmd.mul       = MUL_NONE;
        cmd.div_start = 1'b0;
        cmd.div_sel   = DIV_INTEG;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid) cmd.op = DP_LOAD;
            end
            ST_ANGLE:     cmd.mul = MUL_ANGLE;
            ST_ERR:       cmd.op  = DP_ERR;
            ST_CHECK:
            begin
                cmd.op  = DP_CHECK;
                cmd.mul = MUL_ERR_US;
            end
            ST_IDIV:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_INTEG;
                cmd.mul       = MUL_DIFF;
            end
            ST_IDIV_WAIT:
            begin
                if (stat.div_done) cmd.op = DP_INTEG;
            end
            ST_DDIV:
            begin
                cmd.div_sel = DIV_DERIV;
                if (stat.us_zero)
                begin
                    cmd.op = DP_DZERO;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                end
            end
            ST_DDIV_WAIT:
            begin
                cmd.div_sel = DIV_DERIV;
                if (stat.div_done) cmd.op = DP_DERIV;
            end
            ST_KP:
            begin
                cmd.op  = DP_PREV;
                cmd.mul = MUL_KP;
            end
            ST_KI_HI:
            begin
                cmd.op  = DP_ACC_LOAD;
                cmd.mul = MUL_KI_HI;
            end
            ST_KI_LO:
            begin
                cmd.op  = DP_TMP_HI;
                cmd.mul = MUL_KI_LO;
            end
            ST_KD:
            begin
                cmd.op  = DP_TMP_ADD;
                cmd.mul = MUL_KD;
            end
            ST_SUM1:      cmd.op = DP_SUM1;
            ST_SUM2:      cmd.op = DP_SUM2;
            ST_CLAMP:     cmd.op = DP_CLAMP;
            ST_SPD1:
            begin
                if (!stat.drive_zero) cmd.mul = MUL_DRV;
            end
            ST_SPD2:
            begin
                cmd.op  = DP_ACC_LOAD;
                cmd.mul = MUL_OFF;
            end
            ST_SPD3:      cmd.op = DP_SPD_ADD;
            ST_SDIV:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_SPEED;
            end
            ST_SDIV_WAIT:
            begin
                cmd.div_sel = DIV_SPEED;
                if (stat.div_done) cmd.op = DP_SPEED;
            end
            ST_DONE:      res_load = out_free;
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/pid_motor_position_control.sv
// Sequence: a word inside the deadband goes straight to the result; a full update
//   makes up to three passes through the shared two-bit-per-cycle divider; the
//   derivative pass is skipped when elapsed_us is 0, the speed pass when drive is 0.
// Throughput: one word at a time; the next word is taken once the current result
//   sits in the output register, which may still be waiting on m_tready.
// Reset (rst_n, async, active low): registers to their defaults, integral and
//   previous error to zero, output register empty.
module pid_motor_position_control (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // input stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // [15:0] encoder_count, [39:16] elapsed_us
    input  logic [pmpc_pkg::IN_DATA_W-1:0]       s_tdata,
    // output stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [31:0] angle_error, [47:32] drive_output, [63:48] motor_speed
    output logic [pmpc_pkg::OUT_DATA_W-1:0]      m_tdata,
    // [0] updated
    output logic [0:0]                           m_tuser,
    // configuration writes
    input  logic                                 cfg_we,
    input  logic [pmpc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pmpc_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import pmpc_pkg::*;

    cfg_t    cfg_reg, cfg_next;
    logic    m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [0:0]            m_tuser_reg, m_tuser_next;

    dp_cmd_t  cmd;
    dp_stat_t stat;
    result_t  res;
    logic     in_ready;
    logic     res_load;
    logic     out_free;

    // Configuration registers: write enable, index, data; unknown indexes drop
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_SET_POINT:   cfg_next.set_point     = cfg_data;
                REG_GAIN_P:      cfg_next.gain_p        = cfg_data[GAIN_W-1:0];
                REG_GAIN_I:      cfg_next.gain_i        = cfg_data[GAIN_W-1:0];
                REG_GAIN_D:      cfg_next.gain_d        = cfg_data[GAIN_W-1:0];
                REG_DEADBAND:    cfg_next.deadband      = cfg_data[GAIN_W-1:0];
                REG_DEG_PER_CNT: cfg_next.deg_per_count = cfg_data[GAIN_W-1:0];
                REG_DZ_OFFSET:   cfg_next.dz_offset     = cfg_data[GAIN_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.set_point     <= SET_POINT_RST;
            cfg_reg.gain_p        <= GAIN_P_RST;
            cfg_reg.gain_i        <= GAIN_I_RST;
            cfg_reg.gain_d        <= GAIN_D_RST;
            cfg_reg.deadband      <= DEADBAND_RST;
            cfg_reg.deg_per_count <= DEG_PER_CNT_RST;
            cfg_reg.dz_offset     <= DZ_OFFSET_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Sequencer: walks one word through angle, error, deadband check,
    // integral and derivative divides, gain products, clamp and speed scaling
    pmpc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .out_free (out_free),
        .stat     (stat),
        .in_ready (in_ready),
        .res_load (res_load),
        .cmd      (cmd)
    );

    // Datapath: one shared 33x25 multiplier, the shared divider, the
    // accumulators and the loop state (integral, previous error)
    pmpc_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .cfg      (cfg_reg),
        .in_count (s_tdata[COUNT_W-1:0]),
        .in_us    (s_tdata[COUNT_W+US_W-1:COUNT_W]),
        .stat     (stat),
        .res      (res)
    );

    assign s_tready = in_ready;

    // Output register: the result waits here while the sequencer takes the
    // next word; load it only when it is empty or being drained this cycle
    assign out_free = ~m_tvalid_reg | m_tready;

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (res_load)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {res.speed, res.drive, res.angle_error};
            m_tuser_next  = res.updated;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
